@@ hdl/sha_pkg.sv @@
`default_nettype none
package sha_pkg;

    localparam int unsigned QueueDepthDefault = 4;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
    } t_in_req;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_req;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [255:0] INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        begin
            unique case (idx)
                6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

@@ hdl/sha_fifo.sv @@
`default_nettype none
// Small request queue between the input side and the hashing engine.
module sha_fifo
    import sha_pkg::*;
#(
    parameter int unsigned DEPTH = QueueDepthDefault
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    output logic         o_ready,
    input  t_in_req      i_data,
    output logic         o_valid,
    input  wire          i_ready,
    output t_in_req      o_data
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_in_req              r_mem [DEPTH];
    logic [AW-1:0]        r_wr;
    logic [AW-1:0]        r_rd;
    logic [CW-1:0]        r_cnt;
    logic                 push;
    logic                 pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

@@ hdl/sha_engine.sv @@
`default_nettype none
// Block assembly, padding and 64-round compression; emits digest words.
module sha_engine
    import sha_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_valid,
    output logic      o_ready,
    input  t_in_req   i_data,
    output logic      o_valid,
    input  wire       i_ready,
    output t_out_req  o_data
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]   r_state;
    logic [5:0]   r_fill;
    logic [63:0]  r_bits;
    logic [31:0]  r_h [8];
    logic [31:0]  r_w [16];
    logic [31:0]  r_v [8];
    logic [5:0]   r_round;
    logic         r_final;   // block in flight is the last of the message
    logic         r_extra;   // a length-only block still follows
    logic [2:0]   r_idx;
    logic         r_ovalid;
    t_out_req     r_odata;

    logic [31:0]  w_cur;
    logic [31:0]  w_new;
    logic [31:0]  t1;
    logic [31:0]  t2;
    logic [31:0]  s0;
    logic [31:0]  s1;
    logic [31:0]  ch;
    logic [31:0]  maj;
    logic [31:0]  e;
    logic [31:0]  a;
    logic [63:0]  fin_bits;
    logic         out_free;
    logic         pad_here;
    logic [31:0]  pad_word;

    assign o_ready  = (r_state == ST_IDLE);
    assign o_valid  = r_ovalid;
    assign o_data   = r_odata;
    assign out_free = !r_ovalid || i_ready;
    assign fin_bits = r_bits + {55'd0, r_fill, 3'd0};

    always_comb begin
        s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        w_cur = r_w[0];
        e = r_v[4];
        a = r_v[0];
        ch  = (e & r_v[5]) ^ (~e & r_v[6]);
        maj = (a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1 = r_v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ch + round_k(r_round) + w_cur;
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + maj;
    end

    // Next value of word 15 while padding: a fresh word is zero or half of the
    // length, a partial word keeps its bytes, and the pad byte lands at the
    // position where the message ended.
    always_comb begin
        pad_here = (r_fill == r_bits[8:3]) && !r_final && (r_extra == (r_fill >= 6'd56));
        if (r_fill[1:0] == 2'd0) begin
            if (r_extra || r_fill < 6'd56) begin
                pad_word = '0;
            end else begin
                pad_word = (r_fill == 6'd56) ? r_bits[63:32] : r_bits[31:0];
            end
        end else begin
            pad_word = r_w[15];
        end
        if (pad_here) begin
            pad_word[{~r_fill[1:0], 3'b111} -: 8] = 8'h80;
        end
    end

    // The schedule window r_w doubles as the byte assembly buffer: bytes
    // shift into word 15 and words shift down, so word 0 is the oldest.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill   <= '0;
            r_bits   <= '0;
            r_round  <= '0;
            r_final  <= 1'b0;
            r_extra  <= 1'b0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= INIT_HASH[255-32*i -: 32];
            end
        end else begin
            if (r_state == ST_EMIT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        if (i_data.opcode == OP_ABSORB) begin
                            if (r_fill[1:0] == 2'd0) begin
                                for (int i = 0; i < 15; i++) begin
                                    r_w[i] <= r_w[i+1];
                                end
                                r_w[15] <= {i_data.data_byte, 24'd0};
                            end else begin
                                r_w[15] <= r_w[15] | ({24'd0, i_data.data_byte}
                                           << (5'd8 * (5'd3 - {3'd0, r_fill[1:0]})));
                            end
                            r_fill <= r_fill + 1'b1;
                            if (r_fill == 6'd63) begin
                                r_final <= 1'b0;
                                r_round <= '0;
                                for (int i = 0; i < 8; i++) begin
                                    r_v[i] <= r_h[i];
                                end
                                r_state <= ST_ROUND;
                            end
                        end else begin
                            r_bits  <= fin_bits;
                            r_extra <= (r_fill >= 6'd56);
                            r_state <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    // One padding word per cycle until the block is complete.
                    if (r_fill[1:0] == 2'd0) begin
                        for (int i = 0; i < 15; i++) begin
                            r_w[i] <= r_w[i+1];
                        end
                    end
                    r_w[15] <= pad_word;
                    r_fill <= r_fill + 3'd4 - {4'd0, r_fill[1:0]};
                    if (r_fill >= 6'd60) begin
                        r_final <= !r_extra;
                        r_round <= '0;
                        for (int i = 0; i < 8; i++) begin
                            r_v[i] <= r_h[i];
                        end
                        r_state <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    for (int i = 0; i < 15; i++) begin
                        r_w[i] <= r_w[i+1];
                    end
                    r_w[15] <= w_new;
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= e;
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= a;
                    r_v[0] <= t1 + t2;
                    r_round <= r_round + 1'b1;
                    if (r_round == 6'd63) begin
                        r_state <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    if (r_final) begin
                        r_idx   <= '0;
                        r_state <= ST_EMIT;
                    end else if (r_extra) begin
                        r_extra <= 1'b0;
                        r_final <= 1'b1;
                        r_state <= ST_PAD;
                    end else begin
                        r_bits  <= r_bits + 64'd512;
                        r_state <= ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_odata.digest_word <= r_h[r_idx];
                        r_odata.word_index  <= r_idx;
                        r_odata.last_word   <= (r_idx == 3'd7);
                        r_idx <= r_idx + 1'b1;
                        if (r_idx == 3'd7) begin
                            for (int i = 0; i < 8; i++) begin
                                r_h[i] <= INIT_HASH[255-32*i -: 32];
                            end
                            r_bits  <= '0;
                            r_fill  <= '0;
                            r_final <= 1'b0;
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hdl/sha256_stream_hasher_top.sv @@
`default_nettype none
// Channel   Direction  Handshake            Payload
// request   in         i_valid / o_ready    i_data  (t_in_req: opcode, data_byte)
// digest    out        o_valid / i_ready    o_data  (t_out_req: word, index, last)
//
// The engine takes requests only while idle; the 64th byte of a
// block starts the 64 compression rounds and then the chaining add.
// Finish pads one word per cycle and then compresses the block; when fewer
// than eight bytes remain after the pad byte, a second padded block
// follows. Eight words then leave at one per cycle when taken.
// Reset is synchronous and active low and reloads the initial hash values.
// The request queue keeps accepting while the engine is busy until it is
// full, and the output register holds a word until it is taken.
module sha256_stream_hasher_top
    import sha_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_valid,
    output logic      o_ready,
    input  t_in_req   i_data,
    output logic      o_valid,
    input  wire       i_ready,
    output t_out_req  o_data
);
    logic    q_valid;
    logic    q_ready;
    t_in_req q_data;

    // Front: the queue decouples the requester from the engine.
    sha_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    // Back: assembly, padding, compression and digest output.
    sha_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_data  (q_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );
endmodule
`default_nettype wire
